[src/rcfr_pkg.sv]
// shared types and constants for the relay command frame receiver
// no dependencies
package rcfr_pkg;

  localparam int unsigned POS_W = 6;

  localparam logic [7:0] START_BYTE    = 8'h02;
  localparam logic [7:0] CMD_ALL       = 8'hAA;
  localparam logic [7:0] CMD_SINGLE    = 8'hCC;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
  localparam logic [7:0] FIRST_ARG_POS = 8'd4;

  typedef enum logic [2:0] {
    STATUS_APPLIED     = 3'd0,
    STATUS_SINGLE      = 3'd1,
    STATUS_UNKNOWN_CMD = 3'd2,
    STATUS_CHECK_ERR   = 3'd3,
    STATUS_ID_MISMATCH = 3'd4
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] relay_state;
    logic [7:0] changed_mask;
    logic [7:0] request_arg;
  } result_t;

endpackage

[src/rcfr_parser.sv]
// frame parser: per-byte state update and frame judgment
// depends on rcfr_pkg
module rcfr_parser #(
  parameter int unsigned RELAY_COUNT   = 8,
  parameter int unsigned MAX_FRAME_LEN = 60
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       board_id_i,
  output logic             res_valid_o,
  output rcfr_pkg::result_t res_o
);
  import rcfr_pkg::*;

  localparam logic [7:0] RELAY_MASK = 8'((1 << RELAY_COUNT) - 1);
  localparam logic [POS_W-1:0] TGT_FIRST = POS_W'(4);
  localparam logic [POS_W-1:0] TGT_END   = POS_W'(4 + RELAY_COUNT);
  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_LEN);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] dest_q, dest_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] arg_q, arg_d;
  logic [7:0] tgt_q, tgt_d;
  logic [7:0] relay_q, relay_d;
  logic [POS_W:0] pos_inc;
  logic [2:0] tgt_idx;

  assign pos_inc    = {1'b0, pos_q} + (POS_W+1)'(1);
  assign tgt_idx    = 3'(pos_q - TGT_FIRST);

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    dest_d      = dest_q;
    cmd_d       = cmd_q;
    xor_d       = xor_q;
    arg_d       = arg_q;
    tgt_d       = tgt_q;
    relay_d     = relay_q;
    res_valid_o = 1'b0;
    res_o.status       = STATUS_UNKNOWN_CMD;
    res_o.changed_mask = 8'd0;
    if (fire_i) begin
      if (pos_q == '0) begin
        if (byte_i == START_BYTE) begin
          xor_d = byte_i;
          pos_d = POS_W'(1);
        end
      end else begin
        xor_d = xor_q ^ byte_i;
        if (pos_q == POS_W'(1)) dest_d = byte_i;
        if (pos_q == POS_W'(2)) len_d = byte_i;
        if (pos_q == POS_W'(3)) cmd_d = byte_i;
        if ({2'b00, pos_q} == FIRST_ARG_POS) arg_d = byte_i;
        if (pos_q >= TGT_FIRST && pos_q < TGT_END) tgt_d[tgt_idx] = byte_i[0];
        if (pos_inc >= (POS_W+1)'(3)) begin
          if (len_d < MIN_FRAME_LEN || len_d > MAX_LEN) begin
            pos_d = '0;
          end else if ({1'b0, pos_inc} != len_d) begin
            pos_d = pos_inc[POS_W-1:0];
          end else begin
            pos_d       = '0;
            res_valid_o = 1'b1;
            if (dest_d != board_id_i) begin
              res_o.status = STATUS_ID_MISMATCH;
            end else if (xor_d != 8'd0) begin
              res_o.status = STATUS_CHECK_ERR;
            end else if (cmd_d == CMD_ALL) begin
              res_o.status       = STATUS_APPLIED;
              relay_d            = (relay_q & ~RELAY_MASK) | (tgt_d & RELAY_MASK);
              res_o.changed_mask = (relay_q ^ relay_d) & RELAY_MASK;
            end else if (cmd_d == CMD_SINGLE) begin
              res_o.status = STATUS_SINGLE;
            end else begin
              res_o.status = STATUS_UNKNOWN_CMD;
            end
          end
        end else begin
          pos_d = pos_inc[POS_W-1:0];
        end
      end
    end
    res_o.relay_state = relay_d;
    res_o.request_arg = arg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      dest_q  <= '0;
      cmd_q   <= '0;
      xor_q   <= '0;
      arg_q   <= '0;
      tgt_q   <= '0;
      relay_q <= '0;
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      dest_q  <= dest_d;
      cmd_q   <= cmd_d;
      xor_q   <= xor_d;
      arg_q   <= arg_d;
      tgt_q   <= tgt_d;
      relay_q <= relay_d;
    end
  end

  relay_upper_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (relay_q & ~RELAY_MASK) == 8'd0)
    else $error("relay bits beyond relay count set");

  pos_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {2'b00, pos_q} <= MAX_LEN)
    else $error("frame position beyond maximum length");

  result_needs_fire_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire_i && pos_d == '0)
    else $error("result without consumed byte or without return to hunt");

endmodule

[src/rcfr_out_stage.sv]
// result register with valid flag toward the master side
// depends on rcfr_pkg
module rcfr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rcfr_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              valid_o,
  output logic              free_o,
  output rcfr_pkg::result_t res_o
);
  import rcfr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  no_overwrite_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten while held");

  changed_only_applied_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.changed_mask != 8'd0 |-> res_q.status == STATUS_APPLIED)
    else $error("changed mask set on a frame that did not apply relays");

  hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(res_q))
    else $error("held result changed");

endmodule

[src/relay_command_frame_receiver_top.sv]
// top level of the relay command frame receiver
// depends on rcfr_pkg, rcfr_parser and rcfr_out_stage
//
// Takes one received serial byte per cycle on the slave stream and hunts for
// start byte 0x02 frames (id, length, command, arguments, check byte). Each
// completed frame of valid length yields one result transaction: tuser holds
// the status (0 relays applied, 1 single request, 2 unknown command, 3 check
// byte error, 4 id mismatch), tdata the relay states, the changed mask and
// frame byte 4. Bytes outside a frame and frames of bad length give nothing.
// A byte is held in the input register; frame state and result register update
// when it is consumed. A new byte is taken every cycle unless the result
// register is held by a stalled master side. board_id is to be written through
// the config channel while the block is idle; the block does not enforce it.
module relay_command_frame_receiver_top #(
  parameter int unsigned RELAY_COUNT   = 8,
  parameter int unsigned MAX_FRAME_LEN = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] relay_state, [15:8] changed_mask, [23:16] request_arg
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i      // board_id
);
  import rcfr_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic [7:0] board_id_q;
  logic       fire;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      board_id_q <= 8'd0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i) board_id_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) byte_q <= s_axis_tdata;
  end

  rcfr_parser #(
    .RELAY_COUNT  (RELAY_COUNT),
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (byte_q),
    .board_id_i (board_id_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  rcfr_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res),
    .ready_i(m_axis_tready),
    .valid_o(m_axis_tvalid),
    .free_o (out_free),
    .res_o  (out_res)
  );

  assign m_axis_tdata = {out_res.request_arg, out_res.changed_mask, out_res.relay_state};
  assign m_axis_tuser = out_res.status;

  empty_ready_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  byte_consumed_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> !in_valid_q || $past(s_axis_tvalid))
    else $error("input byte not consumed when result stage free");

  status_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= 3'd4)
    else $error("status code out of range");

endmodule
